FILE: rtl/http_chunked_decoder_unit_assert.svh
// Assertion macros shared by the chunked decoder.
// Both macros sample on the rising edge of clk and are disabled while rst is high.
`ifndef HTTP_CHUNKED_DECODER_UNIT_ASSERT_SVH
`define HTTP_CHUNKED_DECODER_UNIT_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define HCD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define HCD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/hcd_pkg.sv
package hcd_pkg;

  localparam int MAX_SIZE_CHARS = 15;
  localparam int COUNT_BITS     = 32;
  localparam int CNT_W          = $clog2(MAX_SIZE_CHARS + 1);

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  localparam logic [1:0] ST_FRAME   = 2'd0;
  localparam logic [1:0] ST_PAYLOAD = 2'd1;
  localparam logic [1:0] ST_DONE    = 2'd2;
  localparam logic [1:0] ST_ERR     = 2'd3;

  // One byte held in the input register.
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } hcd_item_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hcd_hex_t;

  // Decodes an ASCII hex digit of either case.
  function automatic hcd_hex_t hex_decode(input logic [7:0] c);
    hcd_hex_t   h;
    logic [7:0] t;
    h.ok    = 1'b0;
    h.value = 4'd0;
    t       = 8'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      t       = c - 8'h30;
      h.ok    = 1'b1;
      h.value = t[3:0];
    end else if (c >= 8'h61 && c <= 8'h66) begin
      t       = c - 8'h57;
      h.ok    = 1'b1;
      h.value = t[3:0];
    end else if (c >= 8'h41 && c <= 8'h46) begin
      t       = c - 8'h37;
      h.ok    = 1'b1;
      h.value = t[3:0];
    end
    return h;
  endfunction

endpackage

FILE: rtl/hcd_in_stage.sv
module hcd_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_byte,
  input  logic              take,
  output hcd_pkg::hcd_item_t item
);
  import hcd_pkg::*;

  // The register can load a new byte when it is empty or its byte moves on.
  assign in_stall = item.valid && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item.valid <= 1'b0;
    end else if (!in_stall) begin
      item.valid <= in_valid;
    end
    if (in_valid && !in_stall) begin
      item.data <= in_byte;
    end
  end

endmodule

FILE: rtl/hcd_parser.sv
module hcd_parser (
  input  logic              clk,
  input  logic              rst,
  input  hcd_pkg::hcd_item_t item,
  output logic              take,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_byte,
  output logic [1:0]        status
);
  import hcd_pkg::*;

  typedef enum logic [3:0] {
    PH_SIZE,
    PH_SIZE_LF,
    PH_DATA,
    PH_DATA_CR,
    PH_DATA_LF,
    PH_TRAIL_CR,
    PH_TRAIL_LF,
    PH_DONE,
    PH_ERR
  } phase_t;

  phase_t                phase, phase_next;
  logic [COUNT_BITS-1:0] chunk_remaining, chunk_remaining_next;
  logic [CNT_W-1:0]      digit_count, digit_count_next;
  logic [1:0]            st;
  logic [7:0]            ob;
  hcd_hex_t              hex;
  logic                  fire;

  assign take = !out_valid || !out_stall;
  assign fire = item.valid && take;
  assign hex  = hex_decode(item.data);

  always_comb begin
    phase_next           = phase;
    chunk_remaining_next = chunk_remaining;
    digit_count_next     = digit_count;
    st                   = ST_FRAME;
    ob                   = 8'd0;
    unique case (phase)
      PH_SIZE: begin
        if (item.data == CH_CR) begin
          if (digit_count == '0) begin
            phase_next = PH_ERR;
            st         = ST_ERR;
          end else begin
            phase_next = PH_SIZE_LF;
          end
        end else if (!hex.ok || digit_count >= CNT_W'(MAX_SIZE_CHARS) ||
                     chunk_remaining[COUNT_BITS-1 -: 4] != 4'd0) begin
          // Not a digit, too many digits, or the size would overflow.
          phase_next = PH_ERR;
          st         = ST_ERR;
        end else begin
          chunk_remaining_next = {chunk_remaining[COUNT_BITS-5:0], hex.value};
          digit_count_next     = digit_count + CNT_W'(1);
        end
      end
      PH_SIZE_LF: begin
        if (item.data != CH_LF) begin
          phase_next = PH_ERR;
          st         = ST_ERR;
        end else begin
          digit_count_next = '0;
          phase_next = (chunk_remaining == '0) ? PH_TRAIL_CR : PH_DATA;
        end
      end
      PH_DATA: begin
        st                   = ST_PAYLOAD;
        ob                   = item.data;
        chunk_remaining_next = chunk_remaining - COUNT_BITS'(1);
        if (chunk_remaining == COUNT_BITS'(1)) begin
          phase_next = PH_DATA_CR;
        end
      end
      PH_DATA_CR: begin
        if (item.data != CH_CR) begin
          phase_next = PH_ERR;
          st         = ST_ERR;
        end else begin
          phase_next = PH_DATA_LF;
        end
      end
      PH_DATA_LF: begin
        if (item.data != CH_LF) begin
          phase_next = PH_ERR;
          st         = ST_ERR;
        end else begin
          phase_next = PH_SIZE;
        end
      end
      PH_TRAIL_CR: begin
        if (item.data != CH_CR) begin
          phase_next = PH_ERR;
          st         = ST_ERR;
        end else begin
          phase_next = PH_TRAIL_LF;
        end
      end
      PH_TRAIL_LF: begin
        if (item.data != CH_LF) begin
          phase_next = PH_ERR;
          st         = ST_ERR;
        end else begin
          phase_next = PH_DONE;
          st         = ST_DONE;
        end
      end
      default: begin
        // Anything after the body is finished, and every byte after a fault.
        phase_next = PH_ERR;
        st         = ST_ERR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_SIZE;
      chunk_remaining <= '0;
      digit_count     <= '0;
      out_valid       <= 1'b0;
    end else if (fire) begin
      phase           <= phase_next;
      chunk_remaining <= chunk_remaining_next;
      digit_count     <= digit_count_next;
      out_valid       <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (fire) begin
      out_byte <= ob;
      status   <= st;
    end
  end

endmodule

FILE: rtl/http_chunked_decoder_unit.sv
// Chunked HTTP/1.1 body decoder.
// Input channel: in_valid, in_stall, in_byte carry the body one byte per transfer.
// Output channel: out_valid, out_stall, out_byte, status give exactly one result
// per input byte: status 0 for a framing byte, 1 for a payload byte (in out_byte),
// 2 for the final LF of the body, 3 for an error. out_byte is zero unless status is 1.
// Each byte passes through an input register and then a result register, where its
// result is offered to the receiver. The parse step between the two registers is a
// single pass; one byte per cycle is sustained while the receiver does not stall.
// When the receiver stalls, the result register holds its value; the input register
// still takes one more byte, after which in_stall rises until the result is taken.
// Synchronous reset (rst) returns the parser to the start of a size line, clears the
// size and digit count, and empties both registers. Errors are sticky until reset:
// every byte after a fault, or after the body is finished, reports status 3.
module http_chunked_decoder_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic [1:0] status
);
  import hcd_pkg::*;

  `include "http_chunked_decoder_unit_assert.svh"

  hcd_item_t item;
  logic      take;
  logic      out_xfer;
  logic      out_err;

  hcd_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .take     (take),
    .item     (item)
  );

  hcd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .take      (take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .status    (status)
  );

  assign out_xfer = out_valid && !out_stall;
  assign out_err  = (status == ST_ERR);

  `HCD_ASSERT_SAME(a_stall_held, in_stall, item.valid && !take, "stall with no held byte")
  `HCD_ASSERT_SAME(a_byte_zero, out_valid && status != ST_PAYLOAD, out_byte == 8'd0, "stray byte")
  `HCD_ASSERT_NEXT(a_err_sticky, out_xfer && out_err, !out_valid || out_err, "not sticky")
  `HCD_ASSERT_NEXT(a_after_done, out_xfer && status == ST_DONE, !out_valid || out_err, "late byte")

endmodule
